// ===== rtl/p2ntr_pkg.sv =====
// ----------------------------------------------------------------------------
// p2ntr_pkg
// Shared types and codes of the power-of-two nearest-neighbor resampler.
// ----------------------------------------------------------------------------
package p2ntr_pkg;

  // Width of a side register and of the configuration data bus
  localparam int SIDE_W = 9;
  localparam int FMT_W  = 2;
  localparam int PIX_W  = 32;
  localparam int POS_W  = 8;
  localparam int CIDX_W = 2;

  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [FMT_W-1:0]  fmt_t;
  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CIDX_W-1:0] cidx_t;

  // Pixel formats
  localparam fmt_t FMT_RGB16  = 2'd0;
  localparam fmt_t FMT_RGB888 = 2'd1;
  localparam fmt_t FMT_ARGB32 = 2'd2;

  // Configuration register indexes
  localparam cidx_t CFG_WIDTH  = 2'd0;
  localparam cidx_t CFG_HEIGHT = 2'd1;
  localparam cidx_t CFG_FORMAT = 2'd2;

  // Input actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  // Opaque alpha for widened pixels
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Reset values of the registers
  localparam side_t RST_SIDE   = 9'd1;
  localparam fmt_t  RST_FORMAT = FMT_ARGB32;

  // log2 of the smallest power of two not below s (s >= 1)
  function automatic logic [3:0] pow2_log(input side_t s);
    logic [3:0] lg;
    lg = 4'd0;
    for (int i = 0; i < SIDE_W; i++) begin
      if ((10'd1 << i) < {1'b0, s}) begin
        lg = 4'(i + 1);
      end
    end
    return lg;
  endfunction

endpackage

// ===== rtl/p2ntr_pix_if.sv =====
// ----------------------------------------------------------------------------
// p2ntr_pix_if
// Input channel: one load or fetch action with its source pixel.
// ----------------------------------------------------------------------------
interface p2ntr_pix_if;
  import p2ntr_pkg::*;

  logic valid;
  logic ready;
  logic action;
  pix_t pixel_value;

  modport source (output valid, output action, output pixel_value, input ready);
  modport sink   (input valid, input action, input pixel_value, output ready);
endinterface

// ===== rtl/p2ntr_res_if.sv =====
// ----------------------------------------------------------------------------
// p2ntr_res_if
// Result channel: one destination pixel with its position and flags.
// ----------------------------------------------------------------------------
interface p2ntr_res_if;
  import p2ntr_pkg::*;

  logic valid;
  logic ready;
  pix_t out_pixel;
  pos_t out_x;
  pos_t out_y;
  logic last_of_frame;
  logic not_ready;

  modport source (output valid, output out_pixel, output out_x, output out_y,
                  output last_of_frame, output not_ready, input ready);
  modport sink   (input valid, input out_pixel, input out_x, input out_y,
                  input last_of_frame, input not_ready, output ready);
endinterface

// ===== rtl/p2ntr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// p2ntr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface p2ntr_cfg_if;
  import p2ntr_pkg::*;

  logic  valid;
  logic  ready;
  cidx_t index;
  side_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pow2_nearest_texture_resample.sv =====
// ----------------------------------------------------------------------------
// pow2_nearest_texture_resample
// Loads a source image into a frame store and streams it back resized to
// power-of-two sides by nearest-neighbor selection.
// ----------------------------------------------------------------------------
//   channel   role   beat contents
//   -------   ----   ---------------------------------------------------
//   pixels    sink   action, pixel_value
//   results   source out_pixel, out_x, out_y, last_of_frame, not_ready
//   cfg       sink   index (0 width, 1 height, 2 format), data
//
// A load beat is written to the frame store when it is accepted.
// A fetch beat reads the frame store into a read register, and its result
// then moves from that register into the output register; the next beat is
// accepted in the cycle when the result is taken, so fetches do not overlap:
// a new beat waits for the store read and for the single output register.
// Reset (rst, synchronous) clears control state only; frame store contents
// are undefined until loaded. A stalled result holds its register and blocks
// further beats. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module pow2_nearest_texture_resample #(
  parameter int MAX_SIDE  = 256,
  parameter int FRAC_BITS = 8
) (
  input logic clk,
  input logic rst,
  p2ntr_pix_if.sink   pixels,
  p2ntr_res_if.source results,
  p2ntr_cfg_if.sink   cfg
);
  import p2ntr_pkg::*;

  // Largest side the 9-bit registers and MAX_SIDE allow together
  localparam int EFF_MAX = (MAX_SIDE < 511) ? MAX_SIDE : 511;
  localparam int LG_MAX  = $clog2(EFF_MAX);
  localparam int ACC_W   = LG_MAX + FRAC_BITS;
  localparam int STEP_W  = FRAC_BITS + 1;
  localparam int CNT_W   = $clog2(EFF_MAX * EFF_MAX + 1);
  localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam side_t SIDE_CAP = SIDE_W'(EFF_MAX);

  // Configuration registers
  side_t src_w_reg;
  side_t src_h_reg;
  fmt_t  fmt_reg;

  // Fetch position state
  logic [CNT_W-1:0]  load_count;
  logic [LG_MAX-1:0] dest_col;
  logic [LG_MAX-1:0] dest_row;
  logic [ACC_W-1:0]  col_accum;
  logic [ACC_W-1:0]  row_accum;

  // Frame store
  pix_t              frame_store [DEPTH];
  pix_t              rd_data;

  // Beat waiting for store data
  logic              pend;
  pos_t              pend_x;
  pos_t              pend_y;
  logic              pend_last;
  logic              pend_nrdy;

  // Output register
  logic              res_valid;
  pix_t              res_pixel;
  pos_t              res_x;
  pos_t              res_y;
  logic              res_last;
  logic              res_nrdy;

  // Derived geometry
  side_t              eff_w;
  side_t              eff_h;
  logic [3:0]         lgw;
  logic [3:0]         lgh;
  logic [2*SIDE_W-1:0] total;
  logic [STEP_W-1:0]  xstep;
  logic [STEP_W-1:0]  ystep;
  logic [LG_MAX-1:0]  col_end;
  logic [LG_MAX-1:0]  row_end;
  side_t              src_col;
  side_t              src_row;
  logic [2*SIDE_W-1:0] rd_index;
  logic [ADDR_W-1:0]  rd_addr;

  logic               accept;
  logic               do_load;
  logic               do_fetch;
  logic               loaded;
  logic               last_pix;
  logic               restart;
  pix_t               fmt_pixel;

  // Clamp sides and derive steps and end positions
  always_comb begin
    eff_w = (src_w_reg == '0) ? RST_SIDE : ((src_w_reg > SIDE_CAP) ? SIDE_CAP : src_w_reg);
    eff_h = (src_h_reg == '0) ? RST_SIDE : ((src_h_reg > SIDE_CAP) ? SIDE_CAP : src_h_reg);
    lgw   = pow2_log(eff_w);
    lgh   = pow2_log(eff_h);
    total = {{SIDE_W{1'b0}}, eff_w} * {{SIDE_W{1'b0}}, eff_h};
    xstep = STEP_W'(({{FRAC_BITS{1'b0}}, eff_w} << FRAC_BITS) >> lgw);
    ystep = STEP_W'(({{FRAC_BITS{1'b0}}, eff_h} << FRAC_BITS) >> lgh);
    col_end = LG_MAX'((({{SIDE_W{1'b0}}, 1'b1}) << lgw) - 1'b1);
    row_end = LG_MAX'((({{SIDE_W{1'b0}}, 1'b1}) << lgh) - 1'b1);
  end

  // Source position from the accumulators, limited to the last pixel
  always_comb begin
    src_col = SIDE_W'(col_accum >> FRAC_BITS);
    src_row = SIDE_W'(row_accum >> FRAC_BITS);
    if (src_col > eff_w - 1'b1) begin
      src_col = eff_w - 1'b1;
    end
    if (src_row > eff_h - 1'b1) begin
      src_row = eff_h - 1'b1;
    end
    rd_index = {{SIDE_W{1'b0}}, src_row} * {{SIDE_W{1'b0}}, eff_w}
             + {{SIDE_W{1'b0}}, src_col};
    rd_addr  = ADDR_W'(rd_index);
  end

  // Handshake and action decode
  assign pixels.ready = !pend && (!res_valid || results.ready);
  assign cfg.ready    = 1'b1;
  assign accept       = pixels.valid && pixels.ready;
  assign loaded       = (2*SIDE_W)'(load_count) >= total;
  assign do_load      = accept && (pixels.action == ACT_LOAD) && !loaded;
  assign do_fetch     = accept && (pixels.action == ACT_FETCH) && loaded;
  assign last_pix     = (dest_col == col_end) && (dest_row == row_end);
  assign restart      = cfg.valid && cfg.ready &&
                        (cfg.index == CFG_WIDTH || cfg.index == CFG_HEIGHT ||
                         cfg.index == CFG_FORMAT);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_w_reg <= RST_SIDE;
      src_h_reg <= RST_SIDE;
      fmt_reg   <= RST_FORMAT;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_WIDTH:  src_w_reg <= cfg.data;
        CFG_HEIGHT: src_h_reg <= cfg.data;
        CFG_FORMAT: fmt_reg   <= cfg.data[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance load count and fetch position
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      load_count <= '0;
      dest_col   <= '0;
      dest_row   <= '0;
      col_accum  <= '0;
      row_accum  <= '0;
    end else if (do_load) begin
      load_count <= load_count + 1'b1;
    end else if (do_fetch) begin
      if (last_pix) begin
        load_count <= '0;
        dest_col   <= '0;
        dest_row   <= '0;
        col_accum  <= '0;
        row_accum  <= '0;
      end else if (dest_col == col_end) begin
        dest_col   <= '0;
        col_accum  <= '0;
        dest_row   <= dest_row + 1'b1;
        row_accum  <= row_accum + ACC_W'(ystep);
      end else begin
        dest_col   <= dest_col + 1'b1;
        col_accum  <= col_accum + ACC_W'(xstep);
      end
    end
  end

  // Frame store: write on load, registered read on fetch
  always_ff @(posedge clk) begin
    if (do_load) begin
      frame_store[ADDR_W'(load_count)] <= pixels.pixel_value;
    end
    if (do_fetch) begin
      rd_data <= frame_store[rd_addr];
    end
  end

  // Hold fetch details while the store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= accept && (pixels.action == ACT_FETCH);
    end
    if (accept) begin
      pend_nrdy <= !loaded;
      pend_x    <= loaded ? POS_W'(dest_col) : '0;
      pend_y    <= loaded ? POS_W'(dest_row) : '0;
      pend_last <= loaded && last_pix;
    end
  end

  // Widen or mask the store word for the selected format
  always_comb begin
    case (fmt_reg)
      FMT_RGB888: fmt_pixel = {ALPHA_OPAQUE, rd_data[23:0]};
      FMT_RGB16:  fmt_pixel = {16'h0000, rd_data[15:0]};
      default:    fmt_pixel = rd_data;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pend) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
    if (pend) begin
      res_pixel <= pend_nrdy ? '0 : fmt_pixel;
      res_x     <= pend_x;
      res_y     <= pend_y;
      res_last  <= pend_last;
      res_nrdy  <= pend_nrdy;
    end
  end

  assign results.valid         = res_valid;
  assign results.out_pixel     = res_pixel;
  assign results.out_x         = res_x;
  assign results.out_y         = res_y;
  assign results.last_of_frame = res_last;
  assign results.not_ready     = res_nrdy;

endmodule
